>>> rtl/dhf_pkg.sv
// Shared constants, types and helpers of the depth hole fill mode filter.
`timescale 1ns / 1ps
package dhf_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WSZ_W  = $clog2(MAX_WIDTH + 1);
   localparam int HSZ_W  = $clog2(MAX_HEIGHT + 1);
   localparam int ROW_W  = HSZ_W;
   localparam int FCOL_W = $clog2(MAX_WIDTH + 2);
   localparam int LAG_W  = $clog2(2 * MAX_WIDTH + 4);

   localparam int ROW_SLOTS = 16;
   localparam int SLOT_W    = $clog2(ROW_SLOTS);

   localparam int WIN   = 5;
   localparam int WIN_N = WIN * WIN;
   localparam int CNT_W = $clog2(WIN_N + 1);

   localparam int PIX_W = 16;
   localparam logic [PIX_W-1:0] HOLE_LIMIT = 16'd300;

   localparam int ITH_W      = 4;
   localparam int OTH_W      = 5;
   localparam int DIM_W      = 11;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 2;

   localparam int TQ_DEPTH = 4;
   localparam int QPTR_W   = $clog2(TQ_DEPTH);
   localparam int QCNT_W   = $clog2(TQ_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INNER_THR  = 2'd0,
      CSR_OUTER_THR  = 2'd1,
      CSR_IMG_WIDTH  = 2'd2,
      CSR_IMG_HEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_COL0,
      PH_COL1,
      PH_MAIN
   } fetch_phase_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             last;
   } task_type;

   typedef struct packed {
      logic              we;
      logic [SLOT_W-1:0] slot;
      logic [COL_W-1:0]  col;
      logic [PIX_W-1:0]  data;
   } ls_wr_type;

   typedef struct packed {
      logic             re;
      logic [COL_W-1:0] col;
   } ls_rd_type;

   typedef struct packed {
      logic [ITH_W-1:0] inner_thr;
      logic [OTH_W-1:0] outer_thr;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
   } csr_type;

   function automatic logic [WSZ_W-1:0] clamp_w(input logic [DIM_W-1:0] v);
      if (v == '0) return WSZ_W'(1);
      if (32'(v) > MAX_WIDTH) return WSZ_W'(MAX_WIDTH);
      return WSZ_W'(v);
   endfunction

   function automatic logic [HSZ_W-1:0] clamp_h(input logic [DIM_W-1:0] v);
      if (v == '0) return HSZ_W'(1);
      if (32'(v) > MAX_HEIGHT) return HSZ_W'(MAX_HEIGHT);
      return HSZ_W'(v);
   endfunction

endpackage

>>> rtl/dhf_line_store.sv
// Row slot line store: one bank per row slot, one write and one registered read per bank.
`timescale 1ns / 1ps
module dhf_line_store (
   input  logic                 clock,
   input  dhf_pkg::ls_wr_type   ls_wr,
   input  dhf_pkg::ls_rd_type   ls_rd,
   output logic [dhf_pkg::PIX_W-1:0] rd_data [dhf_pkg::ROW_SLOTS]
);
   import dhf_pkg::*;

   for (genvar b = 0; b < ROW_SLOTS; b++) begin : g_bank
      logic [PIX_W-1:0] mem [MAX_WIDTH];
      logic [PIX_W-1:0] rd_ff;

      always_ff @(posedge clock) begin
         if (ls_wr.we && ls_wr.slot == SLOT_W'(b)) begin
            mem[ls_wr.col] <= ls_wr.data;
         end
         if (ls_rd.re) begin
            rd_ff <= mem[ls_rd.col];
         end
      end

      assign rd_data[b] = rd_ff;
   end

endmodule

>>> rtl/dhf_task_fifo.sv
// Short queue of output tasks between the front and the back.
`timescale 1ns / 1ps
module dhf_task_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  dhf_pkg::task_type  push_data,
   input  logic               pop,
   output logic               valid,
   output dhf_pkg::task_type  head,
   output logic               full
);
   import dhf_pkg::*;

   task_type          slot_ff [TQ_DEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in;
   logic [QPTR_W-1:0] rptr_ff, rptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      wptr_in  = push ? wptr_ff + QPTR_W'(1) : wptr_ff;
      rptr_in  = pop ? rptr_ff + QPTR_W'(1) : rptr_ff;
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

   assign valid = (count_ff != '0);
   assign full  = (count_ff == QCNT_W'(TQ_DEPTH));
   assign head  = slot_ff[rptr_ff];

   assert property (@(posedge clock) disable iff (reset) pop |-> valid)
      else $error("task queue popped while empty");

endmodule

>>> rtl/dhf_front.sv
// Front: accepts words, writes the line store, tracks frame position and issues output tasks.
`timescale 1ns / 1ps
module dhf_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [dhf_pkg::PIX_W-1:0]  req_tdata,
   input  logic                       req_tuser,
   input  dhf_pkg::csr_type           csr,
   input  logic                       back_idle,
   input  logic                       tq_full,
   output logic                       tq_push,
   output dhf_pkg::task_type          tq_data,
   output dhf_pkg::ls_wr_type         ls_wr,
   output logic [dhf_pkg::WSZ_W-1:0]  frame_w,
   output logic [dhf_pkg::HSZ_W-1:0]  frame_h
);
   import dhf_pkg::*;

   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;
   logic [LAG_W-1:0] lag_ff, lag_in;
   logic [WSZ_W-1:0] frame_w_ff;
   logic [HSZ_W-1:0] frame_h_ff;

   logic             zero;
   logic [WSZ_W-1:0] cur_w;
   logic [HSZ_W-1:0] cur_h;
   logic             acc;
   logic             wr;
   logic [LAG_W-1:0] lag_plus;
   logic             emit;
   logic             last;

   always_comb begin
      zero  = (in_col_ff == '0) && (in_row_ff == '0) && (out_col_ff == '0) && (out_row_ff == '0);
      cur_w = zero ? clamp_w(csr.width) : frame_w_ff;
      cur_h = zero ? clamp_h(csr.height) : frame_h_ff;

      // hold a new frame until the back has read everything of the old one
      req_tready = !tq_full && (!zero || back_idle);
      acc        = req_tvalid && req_tready;
      wr         = !req_tuser && (in_row_ff < ROW_W'(cur_h));

      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      if (acc && wr) begin
         if (WSZ_W'(in_col_ff) + WSZ_W'(1) >= cur_w) begin
            in_col_in = '0;
            in_row_in = in_row_ff + ROW_W'(1);
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
      end

      lag_plus = lag_ff + LAG_W'(acc && wr);
      emit     = acc && ((lag_plus >= (LAG_W'(cur_w) << 1) + LAG_W'(3))
                         || (in_row_in == ROW_W'(cur_h)));
      last     = (out_row_ff == ROW_W'(cur_h - HSZ_W'(1)))
                 && (WSZ_W'(out_col_ff) + WSZ_W'(1) == cur_w);

      lag_in     = emit ? lag_plus - LAG_W'(1) : lag_plus;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (emit) begin
         if (last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
            lag_in     = '0;
         end else if (WSZ_W'(out_col_ff) + WSZ_W'(1) >= cur_w) begin
            out_col_in = '0;
            out_row_in = out_row_ff + ROW_W'(1);
         end else begin
            out_col_in = out_col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         lag_ff     <= '0;
         frame_w_ff <= WSZ_W'(1);
         frame_h_ff <= HSZ_W'(1);
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         lag_ff     <= lag_in;
         if (acc) begin
            frame_w_ff <= cur_w;
            frame_h_ff <= cur_h;
         end
      end
   end

   assign tq_push      = emit;
   assign tq_data.row  = out_row_ff;
   assign tq_data.col  = out_col_ff;
   assign tq_data.last = last;
   assign ls_wr.we     = acc && wr;
   assign ls_wr.slot   = SLOT_W'(in_row_ff);
   assign ls_wr.col    = in_col_ff;
   assign ls_wr.data   = req_tdata;
   assign frame_w      = frame_w_ff;
   assign frame_h      = frame_h_ff;

   assert property (@(posedge clock) disable iff (reset) emit |-> !tq_full)
      else $error("task issued into a full queue");
   assert property (@(posedge clock) disable iff (reset) (acc && zero) |-> back_idle)
      else $error("frame started while the back still reads the line store");

endmodule

>>> rtl/dhf_back.sv
// Back: fetches window columns, counts valid neighbours, picks the mode and holds the result.
`timescale 1ns / 1ps
module dhf_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       tq_valid,
   input  dhf_pkg::task_type          tq_head,
   output logic                       tq_pop,
   input  logic [dhf_pkg::WSZ_W-1:0]  frame_w,
   input  logic [dhf_pkg::HSZ_W-1:0]  frame_h,
   input  dhf_pkg::csr_type           csr,
   output dhf_pkg::ls_rd_type         ls_rd,
   input  logic [dhf_pkg::PIX_W-1:0]  rd_data [dhf_pkg::ROW_SLOTS],
   output logic                       back_idle,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [dhf_pkg::PIX_W-1:0]  rsp_tdata,
   output logic                       rsp_tuser,
   output logic                       rsp_tlast
);
   import dhf_pkg::*;

   logic stall;

   // fetch sequencer
   task_type        tk_ff, tk_in;
   logic            tk_vld_ff, tk_vld_in;
   fetch_phase_type ph_ff, ph_in;
   logic            issue;
   logic [FCOL_W-1:0] fcol;
   logic [ROW_W:0]  row_sum [WIN];
   logic [WIN-1:0]  row_ok;
   logic            col_ok;

   // column capture
   logic              s1_vld_ff, s1_final_ff, s1_clear_ff, s1_last_ff, s1_colok_ff;
   logic [WIN-1:0]    s1_rowok_ff;
   logic [SLOT_W-1:0] s1_slot_ff;
   logic [SLOT_W-1:0] s1_idx [WIN];

   logic [PIX_W-1:0] win_ff [WIN][WIN];
   logic             wv_ff  [WIN][WIN];
   logic             s2_vld_ff, s2_last_ff;

   // counting
   logic [PIX_W-1:0] val [WIN_N];
   logic [WIN_N-1:0] ok;
   logic [WIN_N-1:0] inner_m;
   logic [WIN_N-1:0] eqm [WIN_N];
   logic [CNT_W-1:0] cnt [WIN_N];
   logic [CNT_W-1:0] inner_cnt, outer_cnt;
   logic             fill;

   logic [PIX_W-1:0] s3_val_ff [WIN_N];
   logic [CNT_W-1:0] s3_cnt_ff [WIN_N];
   logic             s3_vld_ff, s3_fill_ff, s3_last_ff;
   logic [PIX_W-1:0] s3_center_ff;

   logic [CNT_W-1:0] g_best [WIN];
   logic [PIX_W-1:0] g_pick [WIN];

   logic [CNT_W-1:0] s4_best_ff [WIN];
   logic [PIX_W-1:0] s4_pick_ff [WIN];
   logic             s4_vld_ff, s4_fill_ff, s4_last_ff;
   logic [PIX_W-1:0] s4_center_ff;

   logic [CNT_W-1:0] best;
   logic [PIX_W-1:0] pick;

   logic             out_vld_ff, out_fill_ff, out_last_ff;
   logic [PIX_W-1:0] out_data_ff;

   assign stall = out_vld_ff && !rsp_tready;

   // sequencer outputs
   always_comb begin
      issue  = tk_vld_ff && !stall;
      tq_pop = tq_valid && !stall && (!tk_vld_ff || ph_ff == PH_MAIN);
      unique case (ph_ff)
         PH_COL0: fcol = '0;
         PH_COL1: fcol = FCOL_W'(1);
         PH_MAIN: fcol = FCOL_W'(tk_ff.col) + FCOL_W'(2);
         default: fcol = '0;
      endcase
   end

   // sequencer next state
   always_comb begin
      tk_in     = tk_ff;
      tk_vld_in = tk_vld_ff;
      ph_in     = ph_ff;
      if (tq_pop) begin
         tk_in     = tq_head;
         tk_vld_in = 1'b1;
         ph_in     = (tq_head.col == '0) ? PH_COL0 : PH_MAIN;
      end else if (issue) begin
         unique case (ph_ff)
            PH_COL0: ph_in     = PH_COL1;
            PH_COL1: ph_in     = PH_MAIN;
            PH_MAIN: tk_vld_in = 1'b0;
            default: ph_in     = PH_MAIN;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tk_vld_ff <= 1'b0;
         ph_ff     <= PH_MAIN;
      end else begin
         tk_vld_ff <= tk_vld_in;
         ph_ff     <= ph_in;
      end
      tk_ff <= tk_in;
   end

   always_comb begin
      for (int dr = 0; dr < WIN; dr++) begin
         row_sum[dr] = (ROW_W + 1)'(tk_ff.row) + (ROW_W + 1)'(dr);
         row_ok[dr]  = (row_sum[dr] >= (ROW_W + 1)'(2))
                       && (row_sum[dr] < (ROW_W + 1)'(frame_h) + (ROW_W + 1)'(2));
      end
      col_ok = fcol < FCOL_W'(frame_w);
   end

   assign ls_rd.re  = issue;
   assign ls_rd.col = COL_W'(fcol);
   assign back_idle = !tk_vld_ff && !tq_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (!stall) begin
         s1_vld_ff <= issue;
      end
      if (!stall) begin
         s1_final_ff <= (ph_ff == PH_MAIN);
         s1_clear_ff <= (ph_ff == PH_COL0);
         s1_last_ff  <= tk_ff.last;
         s1_colok_ff <= col_ok;
         s1_rowok_ff <= row_ok;
         s1_slot_ff  <= SLOT_W'(tk_ff.row);
      end
   end

   always_comb begin
      for (int r = 0; r < WIN; r++) begin
         s1_idx[r] = s1_slot_ff + SLOT_W'(r) - SLOT_W'(2);
      end
   end

   // shift the fetched column in; a row start drops the columns left of the image
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < WIN; c++) begin
            for (int r = 0; r < WIN; r++) begin
               wv_ff[c][r] <= 1'b0;
            end
         end
         s2_vld_ff <= 1'b0;
      end else if (!stall) begin
         s2_vld_ff <= s1_vld_ff && s1_final_ff;
         if (s1_vld_ff) begin
            for (int c = 0; c < WIN - 1; c++) begin
               for (int r = 0; r < WIN; r++) begin
                  wv_ff[c][r] <= s1_clear_ff ? 1'b0 : wv_ff[c+1][r];
               end
            end
            for (int r = 0; r < WIN; r++) begin
               wv_ff[WIN-1][r] <= s1_colok_ff && s1_rowok_ff[r];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!stall && s1_vld_ff) begin
         for (int c = 0; c < WIN - 1; c++) begin
            for (int r = 0; r < WIN; r++) begin
               win_ff[c][r] <= win_ff[c+1][r];
            end
         end
         for (int r = 0; r < WIN; r++) begin
            win_ff[WIN-1][r] <= rd_data[s1_idx[r]];
         end
      end
      if (!stall) begin
         s2_last_ff <= s1_last_ff;
      end
   end

   // comparator array over the window, column-major order
   always_comb begin
      for (int c = 0; c < WIN; c++) begin
         for (int r = 0; r < WIN; r++) begin
            val[c*WIN + r]     = win_ff[c][r];
            ok[c*WIN + r]      = wv_ff[c][r] && (win_ff[c][r] > HOLE_LIMIT);
            inner_m[c*WIN + r] = ok[c*WIN + r] && (c >= 1) && (c <= 3) && (r >= 1) && (r <= 3);
         end
      end
      for (int k = 0; k < WIN_N; k++) begin
         for (int j = 0; j < WIN_N; j++) begin
            eqm[k][j] = ok[j] && (val[j] == val[k]);
         end
         cnt[k] = ok[k] ? CNT_W'($countones(eqm[k])) : '0;
      end
      inner_cnt = CNT_W'($countones(inner_m));
      outer_cnt = CNT_W'($countones(ok & ~inner_m));
      fill      = (win_ff[2][2] < HOLE_LIMIT)
                  && ((inner_cnt >= CNT_W'(csr.inner_thr)) || (outer_cnt >= CNT_W'(csr.outer_thr)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (!stall) begin
         s3_vld_ff <= s2_vld_ff;
      end
      if (!stall) begin
         for (int k = 0; k < WIN_N; k++) begin
            s3_val_ff[k] <= val[k];
            s3_cnt_ff[k] <= cnt[k];
         end
         s3_fill_ff   <= fill;
         s3_last_ff   <= s2_last_ff;
         s3_center_ff <= win_ff[2][2];
      end
   end

   // first reduction level: strict compare keeps the earliest on ties
   always_comb begin
      for (int g = 0; g < WIN; g++) begin
         g_best[g] = '0;
         g_pick[g] = '0;
         for (int m = 0; m < WIN; m++) begin
            if (s3_cnt_ff[g*WIN + m] > g_best[g]) begin
               g_best[g] = s3_cnt_ff[g*WIN + m];
               g_pick[g] = s3_val_ff[g*WIN + m];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (!stall) begin
         s4_vld_ff <= s3_vld_ff;
      end
      if (!stall) begin
         for (int g = 0; g < WIN; g++) begin
            s4_best_ff[g] <= g_best[g];
            s4_pick_ff[g] <= g_pick[g];
         end
         s4_fill_ff   <= s3_fill_ff;
         s4_last_ff   <= s3_last_ff;
         s4_center_ff <= s3_center_ff;
      end
   end

   always_comb begin
      best = '0;
      pick = '0;
      for (int g = 0; g < WIN; g++) begin
         if (s4_best_ff[g] > best) begin
            best = s4_best_ff[g];
            pick = s4_pick_ff[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (!stall) begin
         out_vld_ff <= s4_vld_ff;
      end
      if (!stall) begin
         out_data_ff <= s4_fill_ff ? pick : s4_center_ff;
         out_fill_ff <= s4_fill_ff;
         out_last_ff <= s4_last_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_fill_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

>>> rtl/depth_hole_fill_mode_filter.sv
// Top level of the depth hole fill mode filter: register file, front, task queue, back.
//
//   channel  dir  signals                      word contents (low bit up)
//   req      in   tvalid tready tdata tuser    tdata: depth_value[15:0]; tuser: kind
//   rsp      out  tvalid tready tdata tuser    tdata: depth_out[15:0]; tuser: was_filled;
//                 tlast                        tlast: frame_last
//   csr      in   we index wdata               index 0..3, wdata[10:0]
//
// One req word per cycle unless the task queue is full; one rsp word per cycle along a row
// unless rsp stalls, plus two extra fetches for the left window columns at each row start.
// From task issue to rsp the data passes the fetch, window capture, count and first mode
// level registers, then the second mode level into the output register.
// The first word of a frame waits until the back has fetched all columns of the last frame.
// Reset is synchronous and clears counters, queue and valid flags; the line store is not cleared.
// A stalled rsp holds the whole back; the front keeps taking words until the task queue fills.
`timescale 1ns / 1ps
module depth_hole_fill_mode_filter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [dhf_pkg::PIX_W-1:0]     req_tdata,   // depth_value
   input  logic                          req_tuser,   // kind
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [dhf_pkg::PIX_W-1:0]     rsp_tdata,   // depth_out
   output logic                          rsp_tuser,   // was_filled
   output logic                          rsp_tlast,   // frame_last
   input  logic                          csr_we,
   input  logic [dhf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dhf_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dhf_pkg::*;

   csr_type    csr_ff;
   ls_wr_type  ls_wr;
   ls_rd_type  ls_rd;
   logic [PIX_W-1:0] rd_data [ROW_SLOTS];
   task_type   tq_data, tq_head;
   logic       tq_push, tq_pop, tq_valid, tq_full;
   logic       back_idle;
   logic [WSZ_W-1:0] frame_w;
   logic [HSZ_W-1:0] frame_h;

   // register file: write only; write it only while the block is idle, the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.inner_thr <= ITH_W'(4);
         csr_ff.outer_thr <= OTH_W'(10);
         csr_ff.width     <= DIM_W'(480);
         csr_ff.height    <= DIM_W'(360);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_INNER_THR:  csr_ff.inner_thr <= ITH_W'(csr_wdata);
            CSR_OUTER_THR:  csr_ff.outer_thr <= OTH_W'(csr_wdata);
            CSR_IMG_WIDTH:  csr_ff.width     <= DIM_W'(csr_wdata);
            CSR_IMG_HEIGHT: csr_ff.height    <= DIM_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   // front: take words, store pixels, issue one task per output pixel
   dhf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr        (csr_ff),
      .back_idle  (back_idle),
      .tq_full    (tq_full),
      .tq_push    (tq_push),
      .tq_data    (tq_data),
      .ls_wr      (ls_wr),
      .frame_w    (frame_w),
      .frame_h    (frame_h)
   );

   // sixteen row slots keep the rows the back still needs while the front runs ahead
   dhf_line_store u_line_store (
      .clock   (clock),
      .ls_wr   (ls_wr),
      .ls_rd   (ls_rd),
      .rd_data (rd_data)
   );

   dhf_task_fifo u_task_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (tq_push),
      .push_data (tq_data),
      .pop       (tq_pop),
      .valid     (tq_valid),
      .head      (tq_head),
      .full      (tq_full)
   );

   // back: window, neighbour counts, mode, output register
   dhf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .tq_valid   (tq_valid),
      .tq_head    (tq_head),
      .tq_pop     (tq_pop),
      .frame_w    (frame_w),
      .frame_h    (frame_h),
      .csr        (csr_ff),
      .ls_rd      (ls_rd),
      .rd_data    (rd_data),
      .back_idle  (back_idle),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> tb/depth_hole_fill_mode_filter_test.sv
// Self-checking testbench of the depth hole fill mode filter.
`timescale 1ns / 1ps
module depth_hole_fill_mode_filter_test;
   import dhf_pkg::*;

   localparam int HALF_HI     = 6;
   localparam int HALF_LO     = 6;
   localparam int STALL_LIMIT = 20000;  // cycles with no word moving on any channel
   localparam int SETTLE      = 24;     // back-end latency plus row fetch, rounded up
   localparam int SLOTS       = 8;

   // One expected output word.
   typedef struct {
      logic [PIX_W-1:0] depth;
      logic             filled;
      logic             last;
   } fill_word_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [PIX_W-1:0]     req_tdata = '0;   // depth_value
   logic                 req_tuser = 1'b0; // kind: 0 pixel, 1 drain
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [PIX_W-1:0]     rsp_tdata;        // depth_out
   logic                 rsp_tuser;        // was_filled
   logic                 rsp_tlast;        // frame_last
   logic                 csr_we = 1'b0;
   csr_index_type        csr_index = CSR_INNER_THR;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Predictor state: row slots, counters, registers and the latched frame size.
   logic [PIX_W-1:0] line_rows [SLOTS][MAX_WIDTH];
   int unsigned inner_thr, outer_thr, img_w, img_h, frame_w, frame_h;
   int unsigned in_col, in_row, out_col, out_row;
   bit          frame_over;
   fill_word_type expected_pixels[$];

   int unsigned error_count = 0;
   int unsigned words_sent = 0;
   int unsigned idle_cycles = 0;
   int unsigned send_idle_pct = 0;
   int unsigned sink_stall_pct = 0;
   logic [PIX_W-1:0] palette [3];

   depth_hole_fill_mode_filter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #HALF_HI clock = 1'b1;
      #HALF_LO clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   function automatic int unsigned clamp_size(input int unsigned v, input int unsigned lim);
      if (v == 0) return 1;
      return (v > lim) ? lim : v;
   endfunction

   // Repair the pending output pixel from its 5x5 neighborhood.
   function automatic void mode_fill(input int unsigned r, input int unsigned c,
                                     output logic [PIX_W-1:0] res, output logic filled);
      logic [PIX_W-1:0] vals [25];
      logic [PIX_W-1:0] v, n, pick;
      int nval, inner, outer, best, cnt, cc, rr;
      v = line_rows[r % SLOTS][c];
      nval = 0; inner = 0; outer = 0;
      res = v;
      filled = 1'b0;
      if (v >= HOLE_LIMIT) return;
      // column-major scan: columns outer, rows inner
      for (int dc = -2; dc <= 2; dc++) begin
         for (int dr = -2; dr <= 2; dr++) begin
            cc = int'(c) + dc;
            rr = int'(r) + dr;
            if (cc < 0 || cc >= int'(frame_w) || rr < 0 || rr >= int'(frame_h)) continue;
            n = line_rows[rr % SLOTS][cc];
            if (n <= HOLE_LIMIT) continue;
            vals[nval] = n;
            nval++;
            if (dc >= -1 && dc <= 1 && dr >= -1 && dr <= 1) inner++;
            else outer++;
         end
      end
      if (inner >= int'(inner_thr) || outer >= int'(outer_thr)) begin
         best = 0;
         pick = '0;
         for (int i = 0; i < nval; i++) begin
            cnt = 0;
            for (int k = 0; k < nval; k++) if (vals[k] == vals[i]) cnt++;
            if (cnt > best) begin
               best = cnt;
               pick = vals[i];
            end
         end
         res = pick;
         filled = 1'b1;
      end
   endfunction

   // Advance the predictor by one accepted word; queue the output it releases.
   function automatic void hole_fill_predict(input logic drain, input logic [PIX_W-1:0] depth);
      int unsigned total, received, pending, need;
      fill_word_type w;
      if (in_col == 0 && in_row == 0 && out_col == 0 && out_row == 0) begin
         frame_w = clamp_size(img_w, MAX_WIDTH);
         frame_h = clamp_size(img_h, MAX_HEIGHT);
      end
      total = frame_w * frame_h;
      received = in_row * frame_w + in_col;
      if (!drain && received < total) begin
         line_rows[in_row % SLOTS][in_col] = depth;
         if (in_col + 1 >= frame_w) begin
            in_col = 0;
            in_row++;
         end else begin
            in_col++;
         end
         received++;
      end
      pending = out_row * frame_w + out_col;
      if (pending >= total) return;
      need = pending + 2 * frame_w + 3;
      if (need > total) need = total;
      if (received < need) return;
      mode_fill(out_row, out_col, w.depth, w.filled);
      w.last = (pending + 1 == total);
      expected_pixels = {expected_pixels, w};
      if (w.last) begin
         in_col = 0; in_row = 0; out_col = 0; out_row = 0;
         frame_over = 1'b1;
      end else if (out_col + 1 >= frame_w) begin
         out_col = 0;
         out_row++;
      end else begin
         out_col++;
      end
   endfunction

   // Send one word; valid stays high into the next word unless the sender idles.
   task automatic send_word(input logic drain, input logic [PIX_W-1:0] depth);
      req_tvalid <= 1'b1;
      req_tuser  <= drain;
      req_tdata  <= depth;
      do @(posedge clock); while (!req_tready);
      hole_fill_predict(drain, depth);
      words_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= PIX_W'($urandom);
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
   endtask

   // Hold off until every expected word is out and the back has drained.
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input int unsigned value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_INNER_THR:  inner_thr = value & 4'hF;
         CSR_OUTER_THR:  outer_thr = value & 5'h1F;
         CSR_IMG_WIDTH:  img_w = value & 11'h7FF;
         CSR_IMG_HEIGHT: img_h = value & 11'h7FF;
         default: ;
      endcase
   endtask

   task automatic configure(input int unsigned ith, input int unsigned oth,
                            input int unsigned w, input int unsigned h);
      wait_quiet();
      csr_write(CSR_INNER_THR, ith);
      csr_write(CSR_OUTER_THR, oth);
      csr_write(CSR_IMG_WIDTH, w);
      csr_write(CSR_IMG_HEIGHT, h);
   endtask

   // Mix holes, the boundary values, a small palette (for modes and ties) and noise.
   function automatic logic [PIX_W-1:0] pick_depth();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 35) return PIX_W'($urandom_range(299));
      if (r < 40) return PIX_W'(300);
      if (r < 45) return PIX_W'(301);
      if (r < 85) return palette[$urandom_range(2)];
      return PIX_W'($urandom);
   endfunction

   // Push a whole frame, with stray early drains when noisy, then flush with drains (and surplus pixels when noisy).
   task automatic run_frame(input int unsigned npix, input bit noisy);
      frame_over = 1'b0;
      for (int unsigned i = 0; i < npix; i++) begin
         if (noisy && $urandom_range(99) < 5) send_word(1'b1, PIX_W'($urandom));
         send_word(1'b0, pick_depth());
      end
      while (!frame_over) begin
         if (noisy && $urandom_range(99) < 20) send_word(1'b0, PIX_W'($urandom));
         else send_word(1'b1, PIX_W'($urandom));
      end
   endtask

   // Center hole with a two-way tie; an edge hole; both boundary values.
   task automatic test_directed_window();
      logic [PIX_W-1:0] px [9];
      px = '{16'd301, 16'd500, 16'd300,
             16'd299, 16'd0,   16'hFFFF,
             16'd500, 16'd301, 16'd1000};
      configure(4, 10, 3, 3);
      frame_over = 1'b0;
      send_word(1'b1, 16'h5A5A);  // drain before the frame ends: ignored
      foreach (px[i]) send_word(1'b0, px[i]);
      while (!frame_over) send_word(1'b1, 16'h0000);
   endtask

   // Zero thresholds fill even an all-hole neighborhood with zero.
   task automatic test_zero_thresholds();
      configure(0, 0, 4, 2);
      frame_over = 1'b0;
      for (int i = 0; i < 8; i++) send_word(1'b0, PIX_W'(i * 37));
      while (!frame_over) send_word(1'b1, 16'h0000);
   endtask

   // Size and threshold extremes; a zero size counts as one.
   task automatic test_size_extremes();
      palette = '{16'd301, 16'd302, 16'd1200};
      configure(9, 17, 0, 0);
      run_frame(1, 1'b0);
      configure(1, 1, 64, 1);
      run_frame(64, 1'b0);
      configure(2, 3, 1, 30);
      run_frame(30, 1'b1);
      configure(9, 17, 5, 5);
      run_frame(25, 1'b1);
   endtask

   // Random frames, mostly small, with random thresholds.
   task automatic test_random_frames(input int unsigned n_words);
      int unsigned stop_at, w, h;
      stop_at = words_sent + n_words;
      while (words_sent < stop_at) begin
         w = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
         h = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 7);
         palette[0] = PIX_W'($urandom_range(301, 400));
         palette[1] = PIX_W'($urandom_range(301, 400));
         palette[2] = PIX_W'($urandom);
         configure($urandom_range(9), $urandom_range(17), w, h);
         run_frame(w * h, 1'b1);
      end
   endtask

   // Check every result word against the oldest prediction; drive random backpressure.
   always @(posedge clock) begin
      fill_word_type w;
      if (rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected word depth=%0d", rsp_tdata));
         end else begin
            w = expected_pixels.pop_front();
            if (rsp_tdata !== w.depth)
               report_mismatch($sformatf("depth_out %0d, want %0d", rsp_tdata, w.depth));
            if (rsp_tuser !== w.filled)
               report_mismatch($sformatf("was_filled %0b, want %0b", rsp_tuser, w.filled));
            if (rsp_tlast !== w.last)
               report_mismatch($sformatf("frame_last %0b, want %0b", rsp_tlast, w.last));
         end
      end
      rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
   end

   // Watchdog: end the run when no word moves for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      inner_thr = 4; outer_thr = 10; img_w = 480; img_h = 360;
      frame_w = 480; frame_h = 360;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      palette = '{16'd301, 16'd700, 16'd701};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 25; sink_stall_pct = 63;
      test_directed_window();
      test_zero_thresholds();
      test_size_extremes();
      test_random_frames(120);
      send_idle_pct = 63; sink_stall_pct = 25;
      test_random_frames(120);
      send_idle_pct = 0; sink_stall_pct = 0;
      test_random_frames(120);

      wait_quiet();
      if (error_count == 0 && expected_pixels.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/dhf_pkg.sv
rtl/dhf_line_store.sv
rtl/dhf_task_fifo.sv
rtl/dhf_front.sv
rtl/dhf_back.sv
rtl/depth_hole_fill_mode_filter.sv
tb/depth_hole_fill_mode_filter_test.sv
